// File: hdl/sprite_frame_animation_sequencer_defines.svh
// Assertion helpers for the sequencer checker.
`ifndef SPRITE_FRAME_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_ANIMATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define SFAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfas checker: same-cycle property failed");

// Next-cycle implication.
`define SFAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfas checker: next-cycle property failed");

`endif

// File: hdl/sfas_pkg.sv
`timescale 1ns / 1ps

package sfas_pkg;

	localparam int SFAS_ANIMATIONS      = 16;
	localparam int SFAS_FRAMES_PER_ANIM = 16;
	localparam int SFAS_TILE_BITS       = 8;
	localparam int SFAS_TIME_BITS       = 16;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_SELECT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_LOADED   = 2'd2,
		ST_ZERO_DUR = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] delta;
		logic [3:0]  anim_id;
		logic [3:0]  frame_slot;
		logic [7:0]  tile_id;
		logic [15:0] duration;
		logic        last_frame;
	} item_t;

	typedef struct packed {
		logic        active;
		logic [3:0]  current_anim;
		logic [3:0]  current_frame;
		logic [7:0]  current_tile;
		logic        frame_changed;
		status_t     status;
	} result_t;

endpackage

// File: hdl/sprite_frame_animation_sequencer.sv
// Loads, reselects, rejected items and ticks with nothing selected pass the execute,
// fetch and tile states before done pulses; busy is high from acceptance until done, so
// a new item is taken only once the last is done. A select of a new animation first sums
// its frame durations, one frame-memory read each. A tick reads and compares the current
// frame and each it steps over, after the remainder divider if the period is reached.
// Reset: nothing selected, all frame counts zero; frame memory is not cleared.
`timescale 1ns / 1ps

module sprite_frame_animation_sequencer
	import sfas_pkg::*;
#(
	parameter int ANIMATIONS      = SFAS_ANIMATIONS,
	parameter int FRAMES_PER_ANIM = SFAS_FRAMES_PER_ANIM,
	parameter int TILE_BITS       = SFAS_TILE_BITS,
	parameter int TIME_BITS       = SFAS_TIME_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int AB    = (ANIMATIONS > 1) ? $clog2(ANIMATIONS) : 1;
	localparam int FB    = (FRAMES_PER_ANIM > 1) ? $clog2(FRAMES_PER_ANIM) : 1;
	localparam int DEPTH = ANIMATIONS * FRAMES_PER_ANIM;
	localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = TIME_BITS + 1;
	localparam int PW    = TIME_BITS + FB;
	localparam int DW    = TILE_BITS + TIME_BITS;
	localparam int DCW   = $clog2(EW + 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_EXEC     = 8'b0000_0010,
		S_SUM      = 8'b0000_0100,
		S_FETCH    = 8'b0000_1000,
		S_TILE     = 8'b0001_0000,
		S_DIV      = 8'b0010_0000,
		S_STEP_RD  = 8'b0100_0000,
		S_STEP_CMP = 8'b1000_0000
	} state_t;

	function automatic logic [MAW-1:0] addr_of(input logic [AB-1:0] anim,
		input logic [FB-1:0] frame);
		addr_of = MAW'(MAW'(anim) * MAW'(FRAMES_PER_ANIM) + MAW'(frame));
	endfunction

	state_t             state_q;
	item_t              item_q;
	logic [AB-1:0]      sel_q;
	logic               selv_q;
	logic [FB-1:0]      frame_q;
	logic [EW-1:0]      elapsed_q;
	logic [PW-1:0]      period_q;
	logic [FB:0]        count_q;
	logic [FB:0]        fc_q [ANIMATIONS];
	logic               chg_q;
	status_t            stat_q;
	logic [FB:0]        sidx_q;
	logic               rdv_s1;
	logic [PW-1:0]      rem_q;
	logic [EW-1:0]      dvd_q;
	logic [DCW-1:0]     dcnt_q;
	logic               done_q;
	result_t            result_q;

	logic [DW-1:0]      mem [DEPTH];
	logic [DW-1:0]      rd_q;
	logic [MAW-1:0]     mem_addr;
	logic               mem_we;

	logic [AB-1:0]        anim_idx;
	logic [FB-1:0]        slot_idx;
	logic                 anim_ok;
	logic                 slot_ok;
	logic [TIME_BITS-1:0] dur_in;
	logic [TIME_BITS-1:0] delta_in;
	logic [TILE_BITS-1:0] tile_in;
	logic [TIME_BITS-1:0] rd_dur;
	logic [TILE_BITS-1:0] rd_tile;
	logic [EW-1:0]        tick_sum;
	logic [PW:0]          trial;
	logic [PW-1:0]        rem_next;
	logic [FB:0]          frame_inc;

	assign anim_idx = AB'(item_q.anim_id);
	assign slot_idx = FB'(item_q.frame_slot);
	assign anim_ok  = 32'(item_q.anim_id) < ANIMATIONS;
	assign slot_ok  = 32'(item_q.frame_slot) < FRAMES_PER_ANIM;
	assign dur_in   = TIME_BITS'(item_q.duration);
	assign delta_in = TIME_BITS'(item_q.delta);
	assign tile_in  = TILE_BITS'(item_q.tile_id);
	assign rd_dur   = rd_q[TIME_BITS-1:0];
	assign rd_tile  = rd_q[DW-1:TIME_BITS];
	assign tick_sum = elapsed_q + EW'(delta_in);
	assign trial    = {rem_q, dvd_q[EW-1]};
	assign rem_next = (trial >= {1'b0, period_q}) ? PW'(trial - {1'b0, period_q})
		: trial[PW-1:0];
	assign frame_inc = (FB+1)'(frame_q) + 1'b1;

	assign mem_we = (state_q == S_EXEC) && (item_q.command == CMD_LOAD) && anim_ok
		&& slot_ok && (fc_q[anim_idx] == '0) && (dur_in != '0);

	always_comb begin
		unique case (state_q)
			S_EXEC:  mem_addr = addr_of(anim_idx, slot_idx);
			S_SUM:   mem_addr = addr_of(sel_q, FB'(sidx_q));
			default: mem_addr = addr_of(sel_q, frame_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= {tile_in, dur_in};
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_TILE) || ((state_q == S_STEP_CMP)
			&& ((rd_dur == '0) || (elapsed_q < EW'(rd_dur))))) begin
			result_q.active        <= selv_q;
			result_q.current_anim  <= 4'(sel_q);
			result_q.current_frame <= 4'(frame_q);
			result_q.current_tile  <= selv_q ? 8'(rd_tile) : 8'd0;
			result_q.frame_changed <= chg_q;
			result_q.status        <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sel_q     <= '0;
			selv_q    <= 1'b0;
			frame_q   <= '0;
			elapsed_q <= '0;
			period_q  <= '0;
			count_q   <= '0;
			chg_q     <= 1'b0;
			stat_q    <= ST_OK;
			sidx_q    <= '0;
			rdv_s1    <= 1'b0;
			rem_q     <= '0;
			dvd_q     <= '0;
			dcnt_q    <= '0;
			done_q    <= 1'b0;
			for (int i = 0; i < ANIMATIONS; i++) begin
				fc_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						chg_q   <= 1'b0;
						stat_q  <= ST_OK;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FETCH;
					case (item_q.command)
						CMD_TICK: begin
							if (selv_q) begin
								if (PW'(tick_sum) >= period_q) begin
									dvd_q   <= tick_sum;
									rem_q   <= '0;
									dcnt_q  <= DCW'(EW);
									chg_q   <= 1'b1;
									state_q <= S_DIV;
								end else begin
									elapsed_q <= tick_sum;
									state_q   <= S_STEP_RD;
								end
							end
						end
						CMD_LOAD: begin
							if (!anim_ok || !slot_ok) begin
								stat_q <= ST_UNKNOWN;
							end else if (fc_q[anim_idx] != '0) begin
								stat_q <= ST_LOADED;
							end else if (dur_in == '0) begin
								stat_q <= ST_ZERO_DUR;
							end else if (item_q.last_frame) begin
								fc_q[anim_idx] <= (FB+1)'(slot_idx) + 1'b1;
							end
						end
						CMD_SELECT: begin
							if (!anim_ok || (fc_q[anim_idx] == '0)) begin
								stat_q <= ST_UNKNOWN;
							end else if (!selv_q || (anim_idx != sel_q)) begin
								sel_q     <= anim_idx;
								selv_q    <= 1'b1;
								frame_q   <= '0;
								elapsed_q <= '0;
								count_q   <= fc_q[anim_idx];
								period_q  <= '0;
								sidx_q    <= '0;
								rdv_s1    <= 1'b0;
								chg_q     <= 1'b1;
								state_q   <= S_SUM;
							end
						end
						default: begin
						end
					endcase
				end
				S_SUM: begin
					if (rdv_s1) begin
						period_q <= period_q + PW'(rd_dur);
					end
					if (sidx_q < count_q) begin
						sidx_q <= sidx_q + 1'b1;
						rdv_s1 <= 1'b1;
					end else begin
						rdv_s1 <= 1'b0;
						if (!rdv_s1) begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_TILE;
				end
				S_TILE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DIV: begin
					rem_q  <= rem_next;
					dvd_q  <= {dvd_q[EW-2:0], 1'b0};
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DCW'(1)) begin
						elapsed_q <= EW'(rem_next);
						state_q   <= S_STEP_RD;
					end
				end
				S_STEP_RD: begin
					state_q <= S_STEP_CMP;
				end
				S_STEP_CMP: begin
					if ((rd_dur == '0) || (elapsed_q < EW'(rd_dur))) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						elapsed_q <= elapsed_q - EW'(rd_dur);
						frame_q   <= (frame_inc >= count_q) ? '0 : FB'(frame_inc);
						chg_q     <= 1'b1;
						state_q   <= S_STEP_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hdl/sfas_checker.sv
`timescale 1ns / 1ps
`include "sprite_frame_animation_sequencer_defines.svh"

module sfas_checker
	import sfas_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	`SFAS_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`SFAS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SFAS_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	`SFAS_ASSERT_IMP(a_idle_tile, clk, arst_n, done && !result.active,
		result.current_tile == 8'd0)
	`SFAS_ASSERT_IMP(a_reject_quiet, clk, arst_n, done && (result.status != ST_OK),
		!result.frame_changed)

endmodule

bind sprite_frame_animation_sequencer sfas_checker u_sfas_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
